[rtl/mk_pkg.sv]
// Shared types, segment kind codes and the character code table of the keyer.
// No dependencies; used by mk_ctrl, mk_dp and morse_keyer_top.
package mk_pkg;

  localparam int UnitW = 12;
  localparam int DurW = 16;
  localparam int CharW = 8;

  localparam logic [11:0] UNIT_RESET = 12'd100;
  localparam logic [15:0] END_GAP_RESET = 16'd5000;

  // Kinds of key segment that the controller asks the datapath to emit.
  localparam logic [2:0] SEG_WORD = 3'd0;
  localparam logic [2:0] SEG_LGAP = 3'd1;
  localparam logic [2:0] SEG_EGAP = 3'd2;
  localparam logic [2:0] SEG_ELEM = 3'd3;
  localparam logic [2:0] SEG_ENDG = 3'd4;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] kind;
    logic       seg_end;
    logic       next_elem;
  } mk_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_code;
    logic gap_owed;
    logic last;
    logic end_gap_nz;
    logic elem_last;
    logic out_free;
  } mk_status_t;

  // Element pattern: element k of the character sits in bit k, a dash is 1.
  typedef struct packed {
    logic       valid;
    logic [2:0] len;
    logic [4:0] pat;
  } mk_code_t;

  function automatic mk_code_t mk_lookup(input logic [7:0] c);
    mk_code_t r;
    r = '{valid: 1'b1, len: 3'd0, pat: 5'b00000};
    case (c)
      "A": begin r.len = 3'd2; r.pat = 5'b00010; end
      "B": begin r.len = 3'd4; r.pat = 5'b00001; end
      "C": begin r.len = 3'd4; r.pat = 5'b00101; end
      "D": begin r.len = 3'd3; r.pat = 5'b00001; end
      "E": begin r.len = 3'd1; r.pat = 5'b00000; end
      "F": begin r.len = 3'd4; r.pat = 5'b00100; end
      "G": begin r.len = 3'd3; r.pat = 5'b00011; end
      "H": begin r.len = 3'd4; r.pat = 5'b00000; end
      "I": begin r.len = 3'd2; r.pat = 5'b00000; end
      "J": begin r.len = 3'd4; r.pat = 5'b01110; end
      "K": begin r.len = 3'd3; r.pat = 5'b00101; end
      "L": begin r.len = 3'd4; r.pat = 5'b00010; end
      "M": begin r.len = 3'd2; r.pat = 5'b00011; end
      "N": begin r.len = 3'd2; r.pat = 5'b00001; end
      "O": begin r.len = 3'd3; r.pat = 5'b00111; end
      "P": begin r.len = 3'd4; r.pat = 5'b00110; end
      "Q": begin r.len = 3'd4; r.pat = 5'b01011; end
      "R": begin r.len = 3'd3; r.pat = 5'b00010; end
      "S": begin r.len = 3'd3; r.pat = 5'b00000; end
      "T": begin r.len = 3'd1; r.pat = 5'b00001; end
      "U": begin r.len = 3'd3; r.pat = 5'b00100; end
      "V": begin r.len = 3'd4; r.pat = 5'b01000; end
      "W": begin r.len = 3'd3; r.pat = 5'b00110; end
      "X": begin r.len = 3'd4; r.pat = 5'b01001; end
      "Y": begin r.len = 3'd4; r.pat = 5'b01101; end
      "Z": begin r.len = 3'd4; r.pat = 5'b00011; end
      "0": begin r.len = 3'd5; r.pat = 5'b11111; end
      "1": begin r.len = 3'd5; r.pat = 5'b11110; end
      "2": begin r.len = 3'd5; r.pat = 5'b11100; end
      "3": begin r.len = 3'd5; r.pat = 5'b11000; end
      "4": begin r.len = 3'd5; r.pat = 5'b10000; end
      "5": begin r.len = 3'd5; r.pat = 5'b00000; end
      "6": begin r.len = 3'd5; r.pat = 5'b00001; end
      "7": begin r.len = 3'd5; r.pat = 5'b00011; end
      "8": begin r.len = 3'd5; r.pat = 5'b00111; end
      "9": begin r.len = 3'd5; r.pat = 5'b01111; end
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/mk_ctrl.sv]
// Sequencing state machine of the keyer: walks the segments of one character.
// Depends on mk_pkg for the command and status structs and segment kinds.
module mk_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mk_pkg::mk_status_t st,
  output mk_pkg::mk_cmd_t    cmd
);
  import mk_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WORD   = 3'd2;
  localparam logic [2:0] S_LGAP   = 3'd3;
  localparam logic [2:0] S_ELEM   = 3'd4;
  localparam logic [2:0] S_EGAP   = 3'd5;
  localparam logic [2:0] S_ENDG   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       end_follows;

  // An end gap is sent after the last character's own segments unless end_gap_ticks is zero.
  assign end_follows = st.last && st.end_gap_nz;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '{load: 1'b0, emit: 1'b0, kind: SEG_WORD, seg_end: 1'b0, next_elem: 1'b0};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_space) begin
          state_next = S_WORD;
        end else if (st.is_code) begin
          state_next = st.gap_owed ? S_LGAP : S_ELEM;
        end else if (end_follows) begin
          state_next = S_ENDG;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WORD: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = SEG_WORD;
          cmd.seg_end = !end_follows;
          state_next = end_follows ? S_ENDG : S_IDLE;
        end
      end
      S_LGAP: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = SEG_LGAP;
          state_next = S_ELEM;
        end
      end
      S_ELEM: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = SEG_ELEM;
          if (st.elem_last) begin
            cmd.seg_end = !end_follows;
            state_next = end_follows ? S_ENDG : S_IDLE;
          end else begin
            cmd.next_elem = 1'b1;
            state_next = S_EGAP;
          end
        end
      end
      S_EGAP: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = SEG_EGAP;
          state_next = S_ELEM;
        end
      end
      S_ENDG: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = SEG_ENDG;
          cmd.seg_end = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/mk_dp.sv]
// Datapath of the keyer: registers, character decode, duration math, output register.
// Depends on mk_pkg for the code table, kind codes and command/status structs.
module mk_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_sel,
  input  logic [31:0]              cfg_wdata,
  output logic [31:0]              cfg_rdata,
  input  logic [mk_pkg::CharW-1:0] char_code,
  input  logic                     last_char,
  input  mk_pkg::mk_cmd_t          cmd,
  output mk_pkg::mk_status_t       st,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     key_level,
  output logic [mk_pkg::DurW-1:0]  duration_ticks,
  output logic                     run_end
);
  import mk_pkg::*;

  logic [UnitW-1:0] unit_ticks;
  logic [DurW-1:0]  end_gap_ticks;
  logic             pending;
  logic             gap_owed;
  logic             is_space;
  logic             is_code;
  logic             last_flag;
  logic [2:0]       code_len;
  logic [4:0]       code_pat;
  logic [2:0]       elem_idx;
  mk_code_t         lk;
  logic             in_space;
  logic [DurW-1:0]  u1;
  logic [DurW-1:0]  u3;
  logic [DurW-1:0]  u6;
  logic [DurW-1:0]  dur;
  logic             level;

  assign lk = mk_lookup(char_code);
  assign in_space = (char_code == CHAR_SPACE);

  // Small multiples of the unit, as shift and add; all fit 16 bits.
  assign u1 = {{(DurW-UnitW){1'b0}}, unit_ticks};
  assign u3 = (u1 << 1) + u1;
  assign u6 = u3 << 1;

  always_comb begin
    dur = u1;
    level = 1'b0;
    case (cmd.kind)
      SEG_WORD: dur = u6;
      SEG_LGAP: dur = u3;
      SEG_EGAP: dur = u1;
      SEG_ELEM: begin
        level = 1'b1;
        dur = code_pat[elem_idx] ? u3 : u1;
      end
      SEG_ENDG: dur = end_gap_ticks;
      default: dur = u1;
    endcase
  end

  assign cfg_rdata = cfg_sel ? {16'd0, end_gap_ticks} : {20'd0, unit_ticks};

  assign st.is_space   = is_space;
  assign st.is_code    = is_code;
  assign st.gap_owed   = gap_owed;
  assign st.last       = last_flag;
  assign st.end_gap_nz = (end_gap_ticks != '0);
  assign st.elem_last  = (elem_idx == code_len - 3'd1);
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_RESET;
      end_gap_ticks <= END_GAP_RESET;
      pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel) begin
          end_gap_ticks <= cfg_wdata[DurW-1:0];
        end else begin
          unit_ticks <= cfg_wdata[UnitW-1:0];
        end
      end
      if (cmd.load) begin
        // The owed gap is decided by the state before this character.
        if (last_char || in_space) begin
          pending <= 1'b0;
        end else if (lk.valid) begin
          pending <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gap_owed <= pending;
      is_space <= in_space;
      is_code <= lk.valid;
      last_flag <= last_char;
      code_len <= lk.len;
      code_pat <= lk.pat;
      elem_idx <= 3'd0;
    end else if (cmd.next_elem) begin
      elem_idx <= elem_idx + 3'd1;
    end
    if (cmd.emit) begin
      key_level <= level;
      duration_ticks <= dur;
      run_end <= cmd.seg_end;
    end
  end

endmodule

[rtl/morse_keyer_top.sv]
// Top level of the Morse keyer: stream ports, APB register port, controller and datapath.
// Depends on mk_pkg, mk_ctrl and mk_dp.
//
// The keyer takes one character per request (A-Z, 0-9 or space, with tlast marking the
// end of a message) and answers with a run of key segments, each a key level and a
// duration in ticks; tlast on the output marks the last segment of a character's run.
// A dot is one unit high, a dash three, elements are separated by one unit low, a
// letter gap of three units low is sent ahead of the next letter or digit, and a space
// sends six units low instead. After the last character an end gap of end_gap_ticks
// low follows unless that register is zero. Any other character code sends nothing of
// its own. One character is worked at a time: it is taken in the idle state, the block
// then passes the decode state and emits its segments one after another, at most eleven
// of them, before it is idle again, and it stays busy longer while the output side
// stalls. The single output register lets the next character be taken while the final
// segment still waits. Registers: unit_ticks at address 0 (12 bits, reset 100) and
// end_gap_ticks at address 4 (16 bits, reset 5000); write them only while the keyer is
// idle.
module morse_keyer_top (
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Character input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  // Segment output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] key_level, [16:1] duration_ticks, [23:17] zero
  output logic        m_tlast    // run_end
);
  import mk_pkg::*;

  mk_cmd_t         cmd;
  mk_status_t      st;
  logic            cfg_we;
  logic            key_level;
  logic [DurW-1:0] duration_ticks;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  mk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mk_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_sel        (paddr[2]),
    .cfg_wdata      (pwdata),
    .cfg_rdata      (prdata),
    .char_code      (s_tdata),
    .last_char      (s_tlast),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .key_level      (key_level),
    .duration_ticks (duration_ticks),
    .run_end        (m_tlast)
  );

  assign m_tdata = {7'd0, duration_ticks, key_level};

endmodule

[rtl/mk_checker.sv]
// Port-level checks of the Morse keyer, attached to the top level by bind.
// Depends only on the ports of morse_keyer_top.
module mk_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // A stalled segment keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output segment changed while stalled");

  // One character at a time: the request after an accept is held off.
  a_one_char: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a character is in work");

  // While a run still has segments to send the keyer cannot be idle.
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("keyer idle in the middle of a run");

  // Reset leaves the keyer ready and with no segment pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid && pready)
    else $error("keyer not idle after reset");

endmodule

bind morse_keyer_top mk_checker u_mk_checker (
  .clk      (clk),
  .rst      (rst),
  .pready   (pready),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[test/tb_morse_keyer_top.sv]
// Self-checking testbench for morse_keyer_top: streams characters in, checks key segments out.
// Depends on mk_pkg (reset values, space code) and the keyer RTL; a scoreboard class inside
// the module predicts every segment, plain tasks drive the stream and APB ports.
module tb_morse_keyer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mk_pkg::*;

  // Register map: one 32-bit word per register.
  localparam logic [2:0] ADDR_UNIT = 3'd0;
  localparam logic [2:0] ADDR_END_GAP = 3'd4;

  // Key levels and the timing of Morse code in dot units.
  localparam logic KEY_DOWN = 1'b1;
  localparam logic KEY_UP = 1'b0;
  localparam int DOT_UNITS = 1;
  localparam int DASH_UNITS = 3;
  localparam int ELEM_GAP_UNITS = 1;
  localparam int LETTER_GAP_UNITS = 3;
  localparam int WORD_GAP_UNITS = 6;

  // The watchdog must outlast the long output hold-off plus the worst random stall runs.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  // Idle cycles after the last segment, so a character that sends nothing is finished too.
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        key_level;
    logic [15:0] duration;
    logic        run_end;
  } key_seg_t;

  // Element string of a character, dots and dashes; empty for codes that send nothing.
  function automatic string morse_pattern(input logic [7:0] c);
    case (c)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      default: return "";
    endcase
  endfunction

  // Keeps its own copy of the registers and of the owed letter gap, turns every accepted
  // character into the segments it must cause and checks the segments in order.
  class morse_scoreboard;
    logic [11:0] unit_ticks;
    logic [15:0] end_gap_ticks;
    bit          gap_owed;
    key_seg_t    segs_due[$];
    int          mismatches;

    function new();
      unit_ticks = UNIT_RESET;
      end_gap_ticks = END_GAP_RESET;
      gap_owed = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [2:0] addr, input logic [31:0] value);
      if (addr == ADDR_UNIT) unit_ticks = value[11:0];
      else if (addr == ADDR_END_GAP) end_gap_ticks = value[15:0];
    endfunction

    function void flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function logic [15:0] span(input int count);
      logic [31:0] t;
      t = unit_ticks * count;
      return t[15:0];
    endfunction

    function key_seg_t seg(input logic level, input logic [15:0] dur);
      seg = '{key_level: level, duration: dur, run_end: 1'b0};
    endfunction

    function void note_char(input logic [7:0] c, input logic last);
      string    pat;
      key_seg_t run[$];
      pat = morse_pattern(c);
      if (c == CHAR_SPACE) begin
        // A space drops any owed letter gap and sends the word gap alone.
        gap_owed = 1'b0;
        run.push_back(seg(KEY_UP, span(WORD_GAP_UNITS)));
      end else if (pat.len() > 0) begin
        if (gap_owed) run.push_back(seg(KEY_UP, span(LETTER_GAP_UNITS)));
        for (int k = 0; k < pat.len(); k++) begin
          if (k > 0) run.push_back(seg(KEY_UP, span(ELEM_GAP_UNITS)));
          run.push_back(seg(KEY_DOWN, span(pat[k] == "-" ? DASH_UNITS : DOT_UNITS)));
        end
        gap_owed = 1'b1;
      end
      // Unknown codes fall through here untouched, except for the end of a message.
      if (last) begin
        gap_owed = 1'b0;
        if (end_gap_ticks != 16'd0) run.push_back(seg(KEY_UP, end_gap_ticks));
      end
      if (run.size() > 0) run[run.size() - 1].run_end = 1'b1;
      foreach (run[i]) segs_due.push_back(run[i]);
    endfunction

    function void check_segment(input logic level, input logic [15:0] dur, input logic last);
      key_seg_t want;
      if (segs_due.size() == 0) begin
        flag_mismatch($sformatf("segment level %0d dur %0d end %0d with none outstanding",
                                level, dur, last));
      end else begin
        want = segs_due.pop_front();
        if (want.key_level !== level || want.duration !== dur || want.run_end !== last)
          flag_mismatch($sformatf("expected level %0d dur %0d end %0d, got %0d %0d %0d",
                                  want.key_level, want.duration, want.run_end,
                                  level, dur, last));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_code
  logic        s_tlast;   // last_char
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [0] key_level, [16:1] duration_ticks, [23:17] zero
  logic        m_tlast;   // run_end

  morse_scoreboard sb;
  int idle_pct = 0;       // chance in 100 that the sender leaves a cycle empty
  int stall_pct = 0;      // chance in 100 that the receiver refuses a cycle
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;
  int chars_sent = 0;

  morse_keyer_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver side. Normally it refuses cycles at random; when a hold-off is asked for it
  // keeps tready low for a long stretch so the keyer backs up and stalls its input.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: every accepted request on either side goes to the scoreboard at the edge that
  // accepts it. The same block keeps the watchdog on cycles without any progress.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_segment(m_tdata[0], m_tdata[16:1], m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // APB access: a setup cycle, then an access cycle that completes at the next edge since
  // pready is always high. Read data is sampled at that completing edge.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_register(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, addr, 32'd0, got);
    if (got !== want)
      sb.flag_mismatch($sformatf("register %0d reads %0d, expected %0d", addr, got, want));
  endtask

  task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, addr, value, unused);
    sb.write_reg(addr, value);
    check_register(addr, value);
  endtask

  // Offers one character and returns at the edge that accepts the request. tvalid stays
  // high into the next request unless the sender decides to idle first.
  task automatic send_char(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  // Stops the input and waits until every predicted segment has come out, then a little
  // longer for a character that sends nothing to pass through the decoder.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.segs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hand-picked characters: shortest and longest codes, the digit with the most segments,
  // a space after a letter, lower case and other codes that send nothing while a letter
  // gap is owed, a message end on an unknown code and on a space, all-zero and all-one codes.
  task automatic directed_chars();
    send_char("E", 1'b0);
    send_char("T", 1'b0);
    send_char(" ", 1'b0);
    send_char("A", 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b1);
    send_char("A", 1'b0);
    send_char(" ", 1'b1);
    send_char("N", 1'b0);
    send_char("a", 1'b0);
    send_char("B", 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char("Z", 1'b0);
    send_char("@", 1'b0);
    send_char("[", 1'b0);
    send_char("/", 1'b0);
    send_char(":", 1'b0);
    send_char("5", 1'b1);
    send_char("1", 1'b0);
    send_char("z", 1'b1);
    send_char("6", 1'b1);
  endtask

  // Mostly whole messages (letters and digits, some spaces, last flag on the final
  // character); the rest are random codes with a random last flag.
  task automatic random_traffic(input int n_chars);
    int          goal;
    int          len;
    logic [7:0]  c;
    goal = chars_sent + n_chars;
    while (chars_sent < goal) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(4) == 0) c = CHAR_SPACE;
          else if ($urandom_range(9) < 7) c = "A" + 8'($urandom_range(25));
          else c = "0" + 8'($urandom_range(9));
          send_char(c, i == len - 1);
        end
      end else begin
        send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(input logic [11:0] unit, input logic [15:0] end_gap,
                           input int idle, input int stall, input bit squeeze,
                           input bit with_directed, input int n_chars);
    set_register(ADDR_UNIT, {20'd0, unit});
    set_register(ADDR_END_GAP, {16'd0, end_gap});
    idle_pct = idle;
    stall_pct = stall;
    hold_pending = squeeze;
    if (with_directed) directed_chars();
    random_traffic(n_chars);
    settle();
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_UNIT;
    pwdata <= 32'd0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'd0;
    s_tlast <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values first, with no idling on either side.
    check_register(ADDR_UNIT, {20'd0, UNIT_RESET});
    check_register(ADDR_END_GAP, {16'd0, END_GAP_RESET});
    directed_chars();
    settle();

    // Smallest non-zero unit with no end gap, free-running handshakes.
    run_phase(12'd1, 16'd0, 0, 0, 1'b0, 1'b0, 60);
    // Largest unit and end gap while the sender idles most of the time.
    run_phase(12'd4095, 16'hFFFF, 86, 0, 1'b0, 1'b1, 60);
    // Receiver stalls most cycles and once holds off long enough to fill the keyer.
    run_phase(12'($urandom_range(4095, 1)), 16'($urandom_range(65535)), 0, 86, 1'b1,
              1'b0, 60);
    // A zero unit gives zero-length segments; both sides idle now and then.
    run_phase(12'd0, 16'd1, 24, 24, 1'b0, 1'b0, 50);
    run_phase(12'($urandom_range(4095, 1)), 16'($urandom_range(65535)), 0, 0, 1'b0,
              1'b0, 70);

    if (sb.mismatches == 0 && sb.segs_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
